@@ hw/rtl/ssca_pkg.sv @@
`default_nettype none
package ssca_pkg;

  localparam int SLOTS_DEF   = 1024;
  localparam int CLUSTER_DEF = 16;
  localparam int REF_MAX_DEF = 32767;

  localparam logic [2:0] REG_ALLOC_ENABLE = 3'd0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_DUP   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_OP_RD,
    S_OP_CK,
    S_A_RD,
    S_A_CK,
    S_B_RD,
    S_B_CK,
    S_C_RD,
    S_C_CK
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [9:0] slot;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  slot_out;
    logic [15:0] ref_count;
    logic [10:0] free_slots;
  } out_t;

endpackage
`default_nettype wire

@@ hw/rtl/swap_slot_cluster_allocator.sv @@
`default_nettype none
// Swap slot allocator. After reset a clearing pass zeroes the count memory, one
// entry a cycle, with busy high. Free, duplicate and query read the count, then
// update it and register the result. Allocate probes the count memory with a
// read state and then a check state per entry, over the cluster, run and
// first-free searches in turn; a disabled or full area answers straight from
// idle with no-space status. Each result word is shown for one cycle on
// out_valid and must be taken then: the receiver cannot hold it off.
// Configuration writes are taken at any time, reads return alloc_enable at
// address 0.
module swap_slot_cluster_allocator #(
  parameter int SLOTS   = ssca_pkg::SLOTS_DEF,
  parameter int CLUSTER = ssca_pkg::CLUSTER_DEF,
  parameter int REF_MAX = ssca_pkg::REF_MAX_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  ssca_pkg::in_t     in_word,
  output logic              out_valid,
  output ssca_pkg::out_t    out_word,
  input  wire               cfg_psel,
  input  wire               cfg_penable,
  input  wire               cfg_pwrite,
  input  wire  [2:0]        cfg_paddr,
  input  wire  [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = $clog2(CLUSTER + 1);

  logic [15:0] mem [SLOTS];
  logic [15:0] rdata_r;
  logic        we_c;
  logic [SW-1:0] waddr_c, raddr_c;
  logic [15:0] wdata_c;

  ssca_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] low_r, low_nxt;
  logic [SW-1:0] high_r, high_nxt;
  logic          hw_r, hw_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic          en_r, en_nxt;
  logic [CW-1:0] bs_r, bs_nxt;
  logic [CW-1:0] k_r, k_nxt;
  ssca_pkg::op_t op_r, op_nxt;
  logic [9:0]    slot_r, slot_nxt;
  logic          ov_r, ov_nxt;
  ssca_pkg::out_t ow_r, ow_nxt;

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    rdata_r <= mem[raddr_c];
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ssca_pkg::REG_ALLOC_ENABLE) ? {31'd0, en_r} : 32'd0;
  assign busy       = (state_r != ssca_pkg::S_IDLE);
  assign out_valid  = ov_r;
  assign out_word   = ow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssca_pkg::S_CLR;
      clr_r   <= '0;
      low_r   <= '0;
      high_r  <= SW'(SLOTS - 1);
      hw_r    <= 1'b0;
      cur_r   <= '0;
      left_r  <= LW'(CLUSTER);
      free_r  <= CW'(SLOTS);
      en_r    <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      hw_r    <= hw_nxt;
      cur_r   <= cur_nxt;
      left_r  <= left_nxt;
      free_r  <= free_nxt;
      en_r    <= en_nxt;
      ov_r    <= ov_nxt;
    end
    bs_r   <= bs_nxt;
    k_r    <= k_nxt;
    op_r   <= op_nxt;
    slot_r <= slot_nxt;
    ow_r   <= ow_nxt;
  end

  always_comb begin
    logic [31:0] heff;
    logic [31:0] tlow;
    logic [31:0] ts;
    logic [31:0] cnt;
    logic        tval;

    state_nxt = state_r;
    clr_nxt   = clr_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    hw_nxt    = hw_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    free_nxt  = free_r;
    en_nxt    = en_r;
    bs_nxt    = bs_r;
    k_nxt     = k_r;
    op_nxt    = op_r;
    slot_nxt  = slot_r;
    ov_nxt    = 1'b0;
    ow_nxt    = ow_r;
    we_c      = 1'b0;
    waddr_c   = '0;
    wdata_c   = '0;
    raddr_c   = '0;
    heff      = hw_r ? 32'hFFFF_FFFF : 32'(high_r);
    tlow      = 32'(low_r);
    ts        = '0;
    tval      = 1'b0;
    cnt       = 32'(rdata_r);

    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr == ssca_pkg::REG_ALLOC_ENABLE) begin
      en_nxt = cfg_pwdata[0];
    end

    case (state_r)
      ssca_pkg::S_CLR: begin
        we_c    = 1'b1;
        waddr_c = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SW'(SLOTS - 1)) begin
          state_nxt = ssca_pkg::S_IDLE;
        end
      end
      ssca_pkg::S_IDLE: begin
        if (start) begin
          op_nxt   = in_word.op;
          slot_nxt = in_word.slot;
          if (in_word.op == ssca_pkg::OP_ALLOC) begin
            if (!en_r || free_r == '0) begin
              ov_nxt = 1'b1;
              ow_nxt = '{ssca_pkg::ST_NOSPACE, 10'd0, 16'd0, 11'(free_r)};
            end else if (left_r != '0) begin
              state_nxt = ssca_pkg::S_A_RD;
            end else begin
              left_nxt  = LW'(CLUSTER);
              bs_nxt    = low_r;
              k_nxt     = low_r;
              state_nxt = ssca_pkg::S_B_RD;
            end
          end else if (32'(in_word.slot) >= 32'(SLOTS)) begin
            ov_nxt = 1'b1;
            ow_nxt = '{ssca_pkg::ST_RANGE, in_word.slot, 16'd0, 11'(free_r)};
          end else begin
            state_nxt = ssca_pkg::S_OP_RD;
          end
        end
      end
      ssca_pkg::S_OP_RD: begin
        raddr_c   = SW'(32'(slot_r));
        state_nxt = ssca_pkg::S_OP_CK;
      end
      ssca_pkg::S_OP_CK: begin
        ov_nxt    = 1'b1;
        state_nxt = ssca_pkg::S_IDLE;
        ow_nxt.status   = ssca_pkg::ST_OK;
        ow_nxt.slot_out = slot_r;
        if (op_r == ssca_pkg::OP_FREE || op_r == ssca_pkg::OP_DUP) begin
          if (cnt == 32'd0) begin
            ow_nxt.status = ssca_pkg::ST_UNUSED;
          end else if (op_r == ssca_pkg::OP_FREE) begin
            if (cnt < 32'(REF_MAX)) begin
              cnt     = cnt - 32'd1;
              we_c    = 1'b1;
              waddr_c = SW'(32'(slot_r));
              wdata_c = 16'(cnt);
              if (cnt == 32'd0) begin
                if (32'(slot_r) < 32'(low_r)) begin
                  low_nxt = CW'(32'(slot_r));
                end
                if (32'(slot_r) > heff) begin
                  high_nxt = SW'(32'(slot_r));
                end
                free_nxt = free_r + 1'b1;
              end
            end
          end else begin
            cnt     = (cnt < 32'(REF_MAX)) ? cnt + 32'd1 : 32'(REF_MAX);
            we_c    = 1'b1;
            waddr_c = SW'(32'(slot_r));
            wdata_c = 16'(cnt);
          end
        end
        ow_nxt.ref_count  = 16'(cnt);
        ow_nxt.free_slots = 11'(free_nxt);
      end
      ssca_pkg::S_A_RD: begin
        if (32'(cur_r) <= heff && 32'(cur_r) < 32'(SLOTS)) begin
          raddr_c   = SW'(32'(cur_r));
          state_nxt = ssca_pkg::S_A_CK;
        end else begin
          left_nxt  = LW'(CLUSTER);
          bs_nxt    = low_r;
          k_nxt     = low_r;
          state_nxt = ssca_pkg::S_B_RD;
        end
      end
      ssca_pkg::S_A_CK: begin
        cur_nxt = cur_r + 1'b1;
        if (rdata_r == 16'd0) begin
          left_nxt = left_r - 1'b1;
          ts       = 32'(cur_r);
          tval     = 1'b1;
        end else begin
          state_nxt = ssca_pkg::S_A_RD;
        end
      end
      ssca_pkg::S_B_RD: begin
        if (32'(bs_r) + 32'(CLUSTER) - 32'd1 <=
            (hw_r ? 32'(SLOTS - 1) : 32'(high_r))) begin
          raddr_c   = SW'(32'(k_r));
          state_nxt = ssca_pkg::S_B_CK;
        end else begin
          k_nxt     = low_r;
          state_nxt = ssca_pkg::S_C_RD;
        end
      end
      ssca_pkg::S_B_CK: begin
        state_nxt = ssca_pkg::S_B_RD;
        if (rdata_r != 16'd0) begin
          bs_nxt = k_r + 1'b1;
          k_nxt  = k_r + 1'b1;
        end else if (32'(k_r) == 32'(bs_r) + 32'(CLUSTER) - 32'd1) begin
          ts   = 32'(bs_r);
          tval = 1'b1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ssca_pkg::S_C_RD: begin
        if (32'(k_r) <= heff && 32'(k_r) < 32'(SLOTS)) begin
          raddr_c   = SW'(32'(k_r));
          state_nxt = ssca_pkg::S_C_CK;
        end else begin
          low_nxt   = CW'(SLOTS - 1);
          high_nxt  = '0;
          hw_nxt    = 1'b0;
          ov_nxt    = 1'b1;
          ow_nxt    = '{ssca_pkg::ST_NOSPACE, 10'd0, 16'd0, 11'(free_r)};
          state_nxt = ssca_pkg::S_IDLE;
        end
      end
      ssca_pkg::S_C_CK: begin
        if (rdata_r == 16'd0) begin
          tlow = 32'(k_r) + 32'd1;
          ts   = 32'(k_r);
          tval = 1'b1;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ssca_pkg::S_C_RD;
        end
      end
      default: begin
        state_nxt = ssca_pkg::S_IDLE;
      end
    endcase

    if (tval) begin
      // take the slot: pull marks in, collapse when they cross
      if (ts == tlow) begin
        tlow = tlow + 32'd1;
      end
      heff = hw_r ? 32'hFFFF_FFFF : 32'(high_r);
      if (!hw_r && ts == heff) begin
        if (heff == 32'd0) begin
          hw_nxt = 1'b1;
        end
        heff = heff - 32'd1;
      end
      if (!hw_nxt && tlow > heff) begin
        low_nxt  = CW'(SLOTS - 1);
        high_nxt = '0;
        hw_nxt   = 1'b0;
      end else begin
        low_nxt  = CW'(tlow);
        high_nxt = SW'(heff);
      end
      we_c      = 1'b1;
      waddr_c   = SW'(ts);
      wdata_c   = 16'd1;
      free_nxt  = free_r - 1'b1;
      cur_nxt   = CW'(ts + 32'd1);
      ov_nxt    = 1'b1;
      ow_nxt    = '{ssca_pkg::ST_OK, 10'(ts), 16'd1, 11'(free_r - 1'b1)};
      state_nxt = ssca_pkg::S_IDLE;
    end
  end

endmodule
`default_nettype wire

@@ bench/swap_slot_cluster_allocator_tb.sv @@
`default_nettype none
module swap_slot_cluster_allocator_tb;

  localparam int NSLOT = ssca_pkg::SLOTS_DEF;
  localparam int CLUS = ssca_pkg::CLUSTER_DEF;
  localparam int RMAX = ssca_pkg::REF_MAX_DEF;
  localparam int WDOG_LIMIT = 40000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ssca_pkg::in_t in_word;
  logic out_valid;
  ssca_pkg::out_t out_word;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  swap_slot_cluster_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // allocator shadow state
  logic [15:0] cnt_mem [NSLOT];
  int unsigned lo_mark, hi_mark, cursor, clus_left, nfree;
  bit en_shadow;

  ssca_pkg::out_t expected_q[$];
  int mismatches;
  int idle_cycles;
  bit fail_flag;

  task automatic mark_taken(input int unsigned s);
    if (s == lo_mark) lo_mark++;
    if (s == hi_mark) hi_mark--;
    if (lo_mark > hi_mark) begin
      lo_mark = NSLOT - 1;
      hi_mark = 0;
    end
    cnt_mem[s] = 16'd1;
    nfree--;
    cursor = s + 1;
  endtask

  task automatic find_slot(output bit ok, output int unsigned got);
    int unsigned s, k;
    bit hit;
    ok = 0;
    got = 0;
    if (clus_left != 0) begin
      while (cursor <= hi_mark && cursor < NSLOT) begin
        s = cursor;
        cursor++;
        if (cnt_mem[s] != 0) continue;
        clus_left--;
        mark_taken(s);
        got = s;
        ok = 1;
        return;
      end
    end
    clus_left = CLUS;
    s = lo_mark;
    while (s + CLUS - 1 <= hi_mark && s + CLUS - 1 < NSLOT) begin
      hit = 0;
      for (k = s; k < s + CLUS; k++) begin
        if (cnt_mem[k] != 0) begin
          s = k + 1;
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        mark_taken(s);
        got = s;
        ok = 1;
        return;
      end
    end
    for (s = lo_mark; s <= hi_mark && s < NSLOT; s++) begin
      if (cnt_mem[s] != 0) continue;
      lo_mark = s + 1;
      mark_taken(s);
      got = s;
      ok = 1;
      return;
    end
    lo_mark = NSLOT - 1;
    hi_mark = 0;
  endtask

  function automatic void reset_shadow();
    foreach (cnt_mem[i]) cnt_mem[i] = '0;
    lo_mark = 0;
    hi_mark = NSLOT - 1;
    cursor = 0;
    clus_left = CLUS;
    nfree = NSLOT;
    en_shadow = 1'b1;
  endfunction

  task automatic predict_alloc(input ssca_pkg::in_t w);
    ssca_pkg::out_t r;
    bit ok;
    int unsigned got, c, sl;
    r = '0;
    sl = w.slot;
    r.slot_out = w.slot;
    if (w.op == ssca_pkg::OP_ALLOC) begin
      r.slot_out = '0;
      if (!en_shadow || nfree == 0) begin
        r.status = ssca_pkg::ST_NOSPACE;
      end else begin
        find_slot(ok, got);
        if (ok) begin
          r.slot_out = got[9:0];
          r.ref_count = 16'd1;
        end else begin
          r.status = ssca_pkg::ST_NOSPACE;
        end
      end
    end else if (sl >= NSLOT) begin
      r.status = ssca_pkg::ST_RANGE;
    end else begin
      c = cnt_mem[sl];
      if (w.op == ssca_pkg::OP_FREE) begin
        if (c == 0) r.status = ssca_pkg::ST_UNUSED;
        else if (c < RMAX) begin
          c--;
          cnt_mem[sl] = c[15:0];
          if (c == 0) begin
            if (sl < lo_mark) lo_mark = sl;
            if (sl > hi_mark) hi_mark = sl;
            nfree++;
          end
        end
      end else if (w.op == ssca_pkg::OP_DUP) begin
        if (c == 0) r.status = ssca_pkg::ST_UNUSED;
        else begin
          if (c < RMAX) c++;
          cnt_mem[sl] = c[15:0];
        end
      end
      r.ref_count = c[15:0];
    end
    r.free_slots = nfree[10:0];
    expected_q.push_back(r);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(input ssca_pkg::op_t op, input logic [9:0] slot, input bit gaps);
    if (gaps) idle_gap();
    start <= 1'b1;
    in_word <= '{op: op, slot: slot};
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_alloc('{op: op, slot: slot});
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ssca_pkg::REG_ALLOC_ENABLE;
    cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    en_shadow = v;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) idle_cycles <= 0;
      else if (out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    ssca_pkg::out_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        fail_flag = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word);
      end else begin
        e = expected_q.pop_front();
        if (out_word.status !== e.status || out_word.slot_out !== e.slot_out ||
            out_word.ref_count !== e.ref_count ||
            out_word.free_slots !== e.free_slots) begin
          fail_flag = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st=%0d slot=%0d cnt=%0d free=%0d %s",
                     e.status, e.slot_out, e.ref_count, e.free_slots,
                     $sformatf("got st=%0d slot=%0d cnt=%0d free=%0d",
                               out_word.status, out_word.slot_out,
                               out_word.ref_count, out_word.free_slots));
        end
      end
    end
  end

  task automatic test_directed();
    send_word(ssca_pkg::OP_QUERY, 10'd0, 0);
    send_word(ssca_pkg::OP_FREE, 10'd1023, 0);
    send_word(ssca_pkg::OP_DUP, 10'd5, 0);
    repeat (3) send_word(ssca_pkg::OP_ALLOC, 10'h3ff, 0);
    send_word(ssca_pkg::OP_DUP, 10'd0, 0);
    send_word(ssca_pkg::OP_QUERY, 10'd0, 0);
    send_word(ssca_pkg::OP_FREE, 10'd1, 0);
    send_word(ssca_pkg::OP_FREE, 10'd1, 0);
    send_word(ssca_pkg::OP_ALLOC, 10'd0, 0);
    send_word(ssca_pkg::OP_QUERY, 10'd1023, 0);
    send_word(ssca_pkg::OP_FREE, 10'd0, 0);
    send_word(ssca_pkg::OP_FREE, 10'd0, 0);
    send_word(ssca_pkg::OP_FREE, 10'd0, 0);
    drain();
    write_enable(1'b0);
    send_word(ssca_pkg::OP_ALLOC, 10'd0, 0);
    send_word(ssca_pkg::OP_QUERY, 10'd2, 0);
    drain();
    write_enable(1'b1);
  endtask

  task automatic test_saturation();
    // repeated duplicates on one slot, then free and query it
    int i;
    for (i = 0; i < 20; i++) send_word(ssca_pkg::OP_DUP, 10'd2, 0);
    send_word(ssca_pkg::OP_FREE, 10'd2, 0);
    send_word(ssca_pkg::OP_QUERY, 10'd2, 0);
    drain();
  endtask

  task automatic test_random(input int n);
    int i, p;
    logic [9:0] s;
    ssca_pkg::op_t op;
    for (i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 45) op = ssca_pkg::OP_ALLOC;
      else if (p < 75) op = ssca_pkg::OP_FREE;
      else if (p < 88) op = ssca_pkg::OP_DUP;
      else op = ssca_pkg::OP_QUERY;
      s = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
      send_word(op, s, 1);
    end
    drain();
  endtask

  task automatic test_fill();
    int i;
    for (i = 0; i < 200; i++) send_word(ssca_pkg::OP_ALLOC, 10'($urandom), 0);
    for (i = 0; i < 40; i++) send_word(ssca_pkg::OP_FREE, 10'($urandom_range(0, 255)), 1);
    for (i = 0; i < 20; i++) send_word(ssca_pkg::OP_ALLOC, 10'd0, 1);
    drain();
    write_enable(1'b0);
    for (i = 0; i < 5; i++) send_word(ssca_pkg::OP_ALLOC, 10'd0, 1);
    drain();
    write_enable(1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    fail_flag = 0;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_saturation();
    test_fill();
    test_random(200);
    drain();
    if (!fail_flag && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
